>>> rtl/itrt_pkg.sv
`timescale 1ns / 1ps
package itrt_pkg;

  localparam int VALUE_WIDTH_DEF    = 32;
  localparam int DIGIT_CAPACITY_DEF = 32;

  localparam logic [6:0] DECIMAL_RADIX   = 7'd10;
  localparam logic [6:0] MIN_RADIX       = 7'd2;
  localparam logic [6:0] MAX_RADIX       = 7'd36;
  localparam logic [7:0] CHAR_ZERO       = 8'h30;
  localparam logic [7:0] CHAR_ALPHA_BASE = 8'h57;  // 'a' - 10
  localparam logic [7:0] CHAR_MINUS      = 8'h2d;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic div_step;
    logic store_digit;
    logic rd_req;
    logic emit_err;
    logic emit_sign;
    logic emit_digit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic err;
    logic neg;
    logic div_done;
    logic quot_zero;
    logic last_digit;
  } dp_sts_t;

  function automatic logic [7:0] digit_char(input logic [5:0] d);
    if (d < 6'(DECIMAL_RADIX)) begin
      digit_char = CHAR_ZERO + 8'(d);
    end else begin
      digit_char = CHAR_ALPHA_BASE + 8'(d);
    end
  endfunction

endpackage

>>> rtl/itrt_ctrl.sv
`timescale 1ns / 1ps
module itrt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  output itrt_pkg::dp_cmd_t cmd,
  input  itrt_pkg::dp_sts_t sts
);
  import itrt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_DIGIT,
    S_RD,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.err) begin
          cmd.emit_err = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cmd.emit_sign = sts.neg;
          state_nxt     = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_DIGIT;
        end
      end
      S_DIGIT: begin
        cmd.store_digit = 1'b1;
        state_nxt = sts.quot_zero ? S_RD : S_DIV;
      end
      S_RD: begin
        cmd.rd_req = 1'b1;
        state_nxt  = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_digit = 1'b1;
        state_nxt = sts.last_digit ? S_IDLE : S_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> rtl/itrt_dp.sv
`timescale 1ns / 1ps
module itrt_dp #(
  parameter int VALUE_WIDTH    = itrt_pkg::VALUE_WIDTH_DEF,
  parameter int DIGIT_CAPACITY = itrt_pkg::DIGIT_CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  itrt_pkg::dp_cmd_t      cmd,
  output itrt_pkg::dp_sts_t      sts,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic signed [6:0]      in_base,
  output logic                   out_valid,
  output logic [7:0]             out_character,
  output logic                   out_last,
  output logic [5:0]             out_length,
  output logic                   out_error
);
  import itrt_pkg::*;

  localparam int CW = $clog2(VALUE_WIDTH);
  localparam int NW = $clog2(DIGIT_CAPACITY + 1);
  localparam int AW = $clog2(DIGIT_CAPACITY);
  localparam int LW = (NW + 1 > 6) ? NW + 1 : 6;

  // base decode
  logic [6:0]             base_u;
  logic [6:0]             radix_full;
  logic                   err_in;
  logic                   neg_in;
  logic [VALUE_WIDTH-1:0] mag_in;

  always_comb begin
    base_u = in_base;
    if (base_u[6]) begin
      radix_full = 7'd0 - base_u;
    end else if (base_u == 7'd0) begin
      radix_full = DECIMAL_RADIX;
    end else begin
      radix_full = base_u;
    end
    err_in = (radix_full < MIN_RADIX) || (radix_full > MAX_RADIX);
    neg_in = (base_u[6] || (base_u == 7'd0)) && in_value[VALUE_WIDTH-1];
    mag_in = neg_in ? (VALUE_WIDTH'(0) - in_value) : in_value;
  end

  logic [VALUE_WIDTH-1:0] quot_r;
  logic [5:0]             rem_r;
  logic [5:0]             radix_r;
  logic                   neg_r;
  logic                   err_r;
  logic [CW-1:0]          bitcnt_r;
  logic [NW-1:0]          cnt_r;
  logic [AW-1:0]          ptr_r;
  logic [5:0]             rdata_r;
  logic [5:0]             mem [DIGIT_CAPACITY];

  // restoring divide, one quotient bit a cycle
  logic [6:0] rem_sh;
  logic [6:0] rem_diff;
  logic       q_bit;
  logic       can_store;

  always_comb begin
    rem_sh    = {rem_r, quot_r[VALUE_WIDTH-1]};
    rem_diff  = rem_sh - {1'b0, radix_r};
    q_bit     = (rem_sh >= {1'b0, radix_r});
    can_store = (cnt_r < NW'(DIGIT_CAPACITY));
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot_r   <= mag_in;
      radix_r  <= radix_full[5:0];
      neg_r    <= neg_in;
      err_r    <= err_in;
      rem_r    <= '0;
      bitcnt_r <= CW'(VALUE_WIDTH - 1);
      cnt_r    <= '0;
      ptr_r    <= '0;
    end else if (cmd.div_step) begin
      quot_r   <= {quot_r[VALUE_WIDTH-2:0], q_bit};
      rem_r    <= q_bit ? rem_diff[5:0] : rem_sh[5:0];
      bitcnt_r <= bitcnt_r - CW'(1);
    end else if (cmd.store_digit) begin
      rem_r    <= '0;
      bitcnt_r <= CW'(VALUE_WIDTH - 1);
      if (can_store) begin
        ptr_r <= cnt_r[AW-1:0];
        cnt_r <= cnt_r + NW'(1);
      end
    end else if (cmd.emit_digit) begin
      ptr_r <= ptr_r - AW'(1);
    end
  end

  // digit store, least significant digit first
  always_ff @(posedge clk) begin
    if (cmd.store_digit && can_store) begin
      mem[cnt_r[AW-1:0]] <= rem_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_req) begin
      rdata_r <= mem[ptr_r];
    end
  end

  logic [LW-1:0] len_full;
  assign len_full = LW'(cnt_r) + LW'(neg_r);

  logic       out_valid_r;
  logic [7:0] out_character_r;
  logic       out_last_r;
  logic [5:0] out_length_r;
  logic       out_error_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_err || cmd.emit_sign || cmd.emit_digit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_err) begin
      out_character_r <= 8'd0;
      out_last_r      <= 1'b1;
      out_length_r    <= 6'd0;
      out_error_r     <= 1'b1;
    end else if (cmd.emit_sign) begin
      out_character_r <= CHAR_MINUS;
      out_last_r      <= 1'b0;
      out_length_r    <= 6'd0;
      out_error_r     <= 1'b0;
    end else if (cmd.emit_digit) begin
      out_character_r <= digit_char(rdata_r);
      out_last_r      <= (ptr_r == '0);
      out_length_r    <= (ptr_r == '0) ? len_full[5:0] : 6'd0;
      out_error_r     <= 1'b0;
    end
  end

  always_comb begin
    sts.err        = err_r;
    sts.neg        = neg_r;
    sts.div_done   = (bitcnt_r == '0);
    sts.quot_zero  = (quot_r == '0);
    sts.last_digit = (ptr_r == '0);
  end

  assign out_valid     = out_valid_r;
  assign out_character = out_character_r;
  assign out_last      = out_last_r;
  assign out_length    = out_length_r;
  assign out_error     = out_error_r;

endmodule

>>> rtl/integer_to_radix_text_unit.sv
`timescale 1ns / 1ps
// channel   handshake          payload
// input     start / busy       in_value, in_base
// result    out_valid strobe   out_character, out_last, out_length, out_error
//
// one item at a time; busy stays high until its last beat has been issued
// each digit is worked out in the shared bit-serial divider, then each digit
// beat takes a digit store read (S_RD) and an emit state (S_EMIT);
// a leading '-' goes out in the check state at no extra cost;
// an error item ends after the check state
// synchronous active-low reset clears the controller and the result strobe
// beats are shown for one cycle only; the receiver cannot stall them
module integer_to_radix_text_unit #(
  parameter int VALUE_WIDTH    = itrt_pkg::VALUE_WIDTH_DEF,
  parameter int DIGIT_CAPACITY = itrt_pkg::DIGIT_CAPACITY_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [VALUE_WIDTH-1:0] in_value,
  input  logic signed [6:0]      in_base,
  output logic                   out_valid,
  output logic [7:0]             out_character,
  output logic                   out_last,
  output logic [5:0]             out_length,
  output logic                   out_error
);
  import itrt_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  itrt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  itrt_dp #(
    .VALUE_WIDTH    (VALUE_WIDTH),
    .DIGIT_CAPACITY (DIGIT_CAPACITY)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_value      (in_value),
    .in_base       (in_base),
    .out_valid     (out_valid),
    .out_character (out_character),
    .out_last      (out_last),
    .out_length    (out_length),
    .out_error     (out_error)
  );

  // an error beat stands alone
  a_err_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last && (out_length == 6'd0))
    else $error("error beat not final or carries a length");

  // more beats to come means the item is still in flight
  a_busy_mid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("idle with text beats still pending");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_text_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && !out_error && (DIGIT_CAPACITY < 63) |-> out_length != 6'd0)
    else $error("final text beat with zero length");

endmodule

>>> dv/tb_integer_to_radix_text_unit.sv
`timescale 1ns / 1ps
module tb_integer_to_radix_text_unit;
  import itrt_pkg::*;

  localparam int STALL_LIMIT  = 20000;
  localparam int RANDOM_ITEMS = 96;
  localparam int DRAIN_CYCLES = 50;

  typedef struct packed {
    logic [7:0] character;
    logic       last_flag;
    logic [5:0] length;
    logic       error_flag;
  } text_beat_t;

  class text_scoreboard;
    text_beat_t text_q[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function int outstanding();
      return text_q.size();
    endfunction

    // works out the full text of one accepted item and queues its beats
    function void note_item(logic [31:0] value, logic [6:0] base);
      int unsigned radix;
      bit          signed_mode;
      logic [31:0] magnitude;
      int unsigned digit;
      int unsigned total;
      logic [7:0]  digit_text[$];
      text_beat_t  beat;
      signed_mode = 1'b0;
      total = 0;
      if (base[6]) begin
        signed_mode = 1'b1;
        radix = 128 - int'(base);
      end else if (base == 7'd0) begin
        signed_mode = 1'b1;
        radix = DECIMAL_RADIX;
      end else begin
        radix = int'(base);
      end
      if (radix < MIN_RADIX || radix > MAX_RADIX) begin
        beat = '{character: 8'd0, last_flag: 1'b1, length: 6'd0, error_flag: 1'b1};
        text_q.push_back(beat);
        return;
      end
      magnitude = value;
      if (signed_mode && value[31]) begin
        beat = '{character: CHAR_MINUS, last_flag: 1'b0, length: 6'd0, error_flag: 1'b0};
        text_q.push_back(beat);
        total++;
        magnitude = 32'd0 - value;
      end
      do begin
        digit = magnitude % radix;
        digit_text.push_front(digit < DECIMAL_RADIX ? CHAR_ZERO + 8'(digit)
                                                    : CHAR_ALPHA_BASE + 8'(digit));
        magnitude = magnitude / radix;
      end while (magnitude != 0);
      total += digit_text.size();
      foreach (digit_text[i]) begin
        beat = '{character: digit_text[i], last_flag: 1'b0, length: 6'd0,
                 error_flag: 1'b0};
        if (i == digit_text.size() - 1) begin
          beat.last_flag = 1'b1;
          beat.length = 6'(total);
        end
        text_q.push_back(beat);
      end
    endfunction

    function void flag_field(string field, logic [7:0] expected_v, logic [7:0] got_v);
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, expected_v, got_v);
      errors++;
    endfunction

    function void check_beat(text_beat_t got);
      text_beat_t want;
      if (text_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %h/%b/%0d/%b", $time,
                 got.character, got.last_flag, got.length, got.error_flag);
        errors++;
        return;
      end
      want = text_q.pop_front();
      if (got.character !== want.character)
        flag_field("character", want.character, got.character);
      if (got.last_flag !== want.last_flag)
        flag_field("last", 8'(want.last_flag), 8'(got.last_flag));
      if (got.length !== want.length)
        flag_field("length", 8'(want.length), 8'(got.length));
      if (got.error_flag !== want.error_flag)
        flag_field("error", 8'(want.error_flag), 8'(got.error_flag));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [31:0]       in_value;
  logic signed [6:0] in_base;
  logic              out_valid;
  logic [7:0]        out_character;
  logic              out_last;
  logic [5:0]        out_length;
  logic              out_error;

  text_scoreboard sb;
  int             stall_cycles;

  integer_to_radix_text_unit uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_value     (in_value),
    .in_base      (in_base),
    .out_valid    (out_valid),
    .out_character(out_character),
    .out_last     (out_last),
    .out_length   (out_length),
    .out_error    (out_error)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      sb.check_beat('{character: out_character, last_flag: out_last,
                      length: out_length, error_flag: out_error});
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("integer_to_radix_text_unit verification failed");
      $finish;
    end
  end

  // start stays high from one item to the next unless an idle gap or a drain lowers it
  task automatic send(logic [31:0] value, logic signed [6:0] base);
    start    <= 1'b1;
    in_value <= value;
    in_base  <= base;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_item(value, base);
  endtask

  task automatic maybe_idle(bit allow);
    if (allow && $urandom_range(0, 99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  endtask

  task automatic drain_text();
    start <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
  endtask

  function automatic logic signed [6:0] pick_base();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 45) return 7'($urandom_range(2, 36));
    if (sel < 85) return 7'(-int'($urandom_range(0, 36)));
    if (sel < 90) return ($urandom_range(0, 1) != 0) ? 7'sd1 : -7'sd1;
    if (sel < 95) return ($urandom_range(0, 1) != 0) ? 7'($urandom_range(37, 63))
                                                    : 7'(-int'($urandom_range(37, 64)));
    return 7'($urandom_range(0, 127));
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1000);
      1: return 32'd0 - 32'($urandom_range(1, 1000));
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'h0000_0000;
          1: return 32'h8000_0000;
          2: return 32'h7fff_ffff;
          default: return 32'hffff_ffff;
        endcase
      end
      3: return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    sb       = new();
    rst_n    = 1'b0;
    start    = 1'b0;
    in_value = '0;
    in_base  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(32'd0, 7'sd10);
    send(32'd0, 7'sd0);
    send(32'hffff_ffff, 7'sd2);
    send(32'h8000_0000, -7'sd2);      // sign plus 32 digits
    send(32'h8000_0000, 7'sd0);
    send(32'hffff_ffff, 7'sd0);
    send(32'h7fff_ffff, -7'sd10);
    send(32'hffff_ffff, 7'sd36);
    send(32'hffff_ffff, -7'sd36);
    send(32'd35, 7'sd36);
    send(32'd10, 7'sd11);
    send(32'd12345, 7'sd10);
    maybe_idle(1'b1);
    send(32'd12345, 7'sd16);
    send(32'd7, 7'sd1);
    send(32'hffff_fff9, -7'sd1);
    send(32'd99, 7'sd37);
    send(32'd99, -7'sd37);
    send(32'h5555_aaaa, 7'sd63);
    send(32'haaaa_5555, -7'sd64);
    send(32'd5, -7'sd5);
    send(32'd0, -7'sd36);
    send(32'h8000_0000, 7'sd2);
    send(32'hdead_beef, 7'sd7);
    send(32'hfedc_ba98, -7'sd3);
    drain_text();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      send(pick_value(), pick_base());
      // steady stretch without random idle gaps in the middle of the run, but for the halfway drain
      maybe_idle(i < 40 || i >= 80);
      if (i == RANDOM_ITEMS / 2) drain_text();
    end

    drain_text();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("integer_to_radix_text_unit verification clean");
    end else begin
      $display("integer_to_radix_text_unit verification failed");
    end
    $finish;
  end

endmodule
